// File: sv/bdac_pkg.sv
// shared types, constants and decade table for the binary to decimal ascii core
`timescale 1ns / 1ps
`default_nettype none
package bdac_pkg;

    localparam int NUM_DECADES = 9;
    localparam int IDX_W       = $clog2(NUM_DECADES + 1);
    localparam int DIGIT_W     = 4;
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new word
        logic sub;        // subtract current power of ten
        logic close_dec;  // finish current decade, move to next
        logic keep_digit; // with close_dec: stage the decade's digit
        logic units;      // stage the units digit as final character
        logic push;       // move staged character into output register
    } bdac_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_neg;     // incoming word is negative in signed mode
        logic ge;         // magnitude still at least the current power of ten
        logic keep;       // digit non-zero or a digit already emitted
        logic at_units;   // all decades done
        logic pend_last;  // staged character is the final one
        logic out_free;   // output register can take a word this cycle
    } bdac_stat_t;

    function automatic logic [VALUE_W-1:0] decade_value(input logic [IDX_W-1:0] idx);
        logic [VALUE_W-1:0] v;
        case (idx)
            4'd0:    v = 32'd1000000000;
            4'd1:    v = 32'd100000000;
            4'd2:    v = 32'd10000000;
            4'd3:    v = 32'd1000000;
            4'd4:    v = 32'd100000;
            4'd5:    v = 32'd10000;
            4'd6:    v = 32'd1000;
            4'd7:    v = 32'd100;
            4'd8:    v = 32'd10;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: sv/bdac_ctrl.sv
// controller state machine sequencing subtraction, digit staging and output
`timescale 1ns / 1ps
`default_nettype none
module bdac_ctrl import bdac_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  bdac_stat_t      stat,
    output bdac_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SUB  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_neg ? ST_EMIT : ST_SUB;
                end
            end
            ST_SUB: begin
                if (stat.at_units) begin
                    cmd.units  = 1'b1;
                    state_next = ST_EMIT;
                end else if (stat.ge) begin
                    cmd.sub = 1'b1;
                end else begin
                    cmd.close_dec = 1'b1;
                    if (stat.keep) begin
                        cmd.keep_digit = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = stat.pend_last ? ST_IDLE : ST_SUB;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/bdac_dp.sv
// datapath: magnitude register, subtractor, digit counter and output register
`timescale 1ns / 1ps
`default_nettype none
module bdac_dp import bdac_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_mode,
    input  wire logic [VALUE_W-1:0] in_value,
    input  bdac_cmd_t               cmd,
    output bdac_stat_t              stat,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [CHAR_W-1:0]       m_char,
    output logic                    m_last
);

    logic [VALUE_W-1:0] mag_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [DIGIT_W-1:0] digit_reg;
    logic               started_reg;
    logic [CHAR_W-1:0]  pend_char_reg;
    logic               pend_last_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic [VALUE_W-1:0] dec_val;
    logic               in_neg;

    assign dec_val = decade_value(idx_reg);
    assign in_neg  = in_mode & in_value[VALUE_W-1];

    assign stat.in_neg    = in_neg;
    assign stat.ge        = (mag_reg >= dec_val);
    assign stat.keep      = (digit_reg != '0) | started_reg;
    assign stat.at_units  = (idx_reg == IDX_W'(NUM_DECADES));
    assign stat.pend_last = pend_last_reg;
    assign stat.out_free  = ~out_valid_reg | m_tready;

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg       <= in_neg ? (~in_value + VALUE_W'(1)) : in_value;
            idx_reg       <= '0;
            digit_reg     <= '0;
            started_reg   <= 1'b0;
            pend_char_reg <= CH_MINUS;
            pend_last_reg <= 1'b0;
        end else if (cmd.sub) begin
            mag_reg   <= mag_reg - dec_val;
            digit_reg <= digit_reg + DIGIT_W'(1);
        end else if (cmd.close_dec) begin
            idx_reg   <= idx_reg + IDX_W'(1);
            digit_reg <= '0;
            if (cmd.keep_digit) begin
                pend_char_reg <= CH_ZERO + CHAR_W'(digit_reg);
                pend_last_reg <= 1'b0;
                started_reg   <= 1'b1;
            end
        end else if (cmd.units) begin
            pend_char_reg <= CH_ZERO + CHAR_W'(mag_reg[DIGIT_W-1:0]);
            pend_last_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_char_reg <= pend_char_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_char   = out_char_reg;
    assign m_last   = out_last_reg;

endmodule
`default_nettype wire

// File: sv/binary_to_decimal_ascii_core.sv
// top level of the binary to decimal ascii converter
`timescale 1ns / 1ps
`default_nettype none
// Converts one 32-bit word to a run of ASCII characters, most significant first.
// s_tuser selects the mode: 0 reads s_tdata as unsigned, 1 as signed two's
// complement. A negative signed word gives a leading '-' followed by its
// magnitude (the most negative word gives '-2147483648'). Leading zeros are
// dropped, the units digit always appears, so zero gives a single '0', and
// m_tlast marks the final character of each number. Each decade digit is
// found by repeated subtraction through a single 32-bit subtractor: a word is
// loaded, any '-' is pushed, each decade is stepped by subtractions until the
// magnitude is below its power of ten and is then closed, a kept digit is
// pushed into the output register before the next decade, the units digit is
// staged and pushed last, and each number gives 1 to 11 characters. A push
// waits while the output register is full and m_tready is low.
// One word is in conversion at a time; s_tready is high only between words.
// The output register lets the next word be taken while the final character
// still waits on m_tready.
module binary_to_decimal_ascii_core import bdac_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input word channel
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,  // [31:0] value
    input  wire logic               s_tuser,  // [0] command: 1 = signed
    // character channel
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [CHAR_W-1:0]       m_tdata,  // [7:0] char_code
    output logic                    m_tlast   // final character of the number
);

    bdac_cmd_t  cmd;
    bdac_stat_t stat;

    // sequencing: idle, subtract loop per decade, wait for output slot
    bdac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // magnitude, digit counting and the output word register
    bdac_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_mode  (s_tuser),
        .in_value (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule
`default_nettype wire
